/* src/csrc_pkg.sv */
// ============================================================================
// csrc_pkg: shared types and constants for the cubic sample rate converter
// Holds sample widths, register indexes and the request structs of both
// channels.
// ============================================================================
package csrc_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_OUT             = 16;
    localparam int CNT_W               = $clog2(MAX_OUT);
    localparam int CFG_INDEX_W         = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP        = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // Four-entry history, entry 0 is the oldest sample.
    typedef sample_t [3:0] hist_t;

    typedef struct packed {
        sample_t left_sample;
        sample_t right_sample;
    } in_req_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
        logic    last_of_run;
    } out_req_t;

    // Controls from the sequencer to both interpolation lanes.
    typedef struct packed {
        logic start;
        logic take;
    } lane_ctl_t;

endpackage

/* src/csrc_lane.sv */
// ============================================================================
// csrc_lane: one channel of cubic Lagrange interpolation
// Horner evaluation with a single shared multiplier, then a divide by six
// through a reciprocal multiply and saturation to the sample width.
// ============================================================================
module csrc_lane #(
    parameter int PHASE_FRAC_BITS = csrc_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csrc_pkg::lane_ctl_t         ctl,
    input  logic [PHASE_FRAC_BITS-1:0]  frac,
    input  csrc_pkg::hist_t             hist,
    output logic                        done,
    output csrc_pkg::sample_t           y
);

    localparam int F      = PHASE_FRAC_BITS;
    localparam int S      = csrc_pkg::SAMPLE_BITS;
    localparam int ACC_W  = S + 6;
    localparam int PROD_W = ACC_W + F + 1;
    localparam int K      = ACC_W + 3;
    localparam int RW     = K - 2;
    localparam int DP_W   = ACC_W + RW;
    localparam int QW     = ACC_W - 2;
    localparam longint unsigned RECIP_L = ((longint'(1) << K) + 5) / 6;
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);
    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [QW-1:0] Q_POS_MAX = QW'((longint'(1) << (S - 1)) - 1);
    localparam logic [QW-1:0] Q_NEG_MAX = QW'(longint'(1) << (S - 1));
    localparam logic signed [S-1:0] S_MAX = {1'b0, {(S - 1){1'b1}}};
    localparam logic signed [S-1:0] S_MIN = {1'b1, {(S - 1){1'b0}}};

    typedef enum logic [6:0] {
        L_IDLE = 7'b0000001,
        L_MUL  = 7'b0000010,
        L_ADD  = 7'b0000100,
        L_MAG  = 7'b0001000,
        L_DIV  = 7'b0010000,
        L_SAT  = 7'b0100000,
        L_DONE = 7'b1000000
    } lane_state_t;

    lane_state_t                state_reg;
    logic [1:0]                 stage_reg;
    logic [F-1:0]               t_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    coef_b_reg;
    logic signed [ACC_W-1:0]    coef_c_reg;
    logic signed [ACC_W-1:0]    coef_d_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic [DP_W-1:0]            dprod_reg;
    csrc_pkg::sample_t          y_reg;

    logic signed [ACC_W-1:0]    v1, v2, v3, v4;
    logic signed [ACC_W-1:0]    coef_a, coef_b, coef_c, coef_d;
    logic signed [ACC_W-1:0]    coef_sel;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   rnd_sum;
    logic signed [PROD_W-1:0]   rnd_shift;
    logic signed [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]           abs_acc;
    logic [DP_W-1:0]            dprod_next;
    logic [QW-1:0]              quot;
    csrc_pkg::sample_t          y_next;

    // Coefficients of the cubic, all scaled by six so they stay integer.
    always_comb
    begin
        v1     = ACC_W'($signed(hist[0]));
        v2     = ACC_W'($signed(hist[1]));
        v3     = ACC_W'($signed(hist[2]));
        v4     = ACC_W'($signed(hist[3]));
        coef_a = ACC_W'(v4 - v1 + (v2 <<< 1) + v2 - (v3 <<< 1) - v3);
        coef_b = ACC_W'((v1 - (v2 <<< 1) + v3) * ACC_W'(3));
        coef_c = ACC_W'((v3 <<< 2) + (v3 <<< 1) - (v1 <<< 1) - (v2 <<< 1) - v2 - v4);
        coef_d = ACC_W'((v2 <<< 2) + (v2 <<< 1));
    end

    always_comb
    begin
        case (stage_reg)
            2'd0:    coef_sel = coef_b_reg;
            2'd1:    coef_sel = coef_c_reg;
            default: coef_sel = coef_d_reg;
        endcase
    end

    assign prod_next  = PROD_W'(acc_reg) * PROD_W'($signed({1'b0, t_reg}));
    assign rnd_sum    = prod_reg + HALF;
    assign rnd_shift  = rnd_sum >>> F;
    assign acc_next   = ACC_W'(rnd_shift) + coef_sel;
    assign abs_acc    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign dprod_next = DP_W'(mag_reg) * DP_W'(RECIP);
    assign quot       = dprod_reg[DP_W-1:K];

    // Round half away from zero is done on the magnitude, then the sign returns.
    always_comb
    begin
        if (neg_reg)
        begin
            if (quot > Q_NEG_MAX)
                y_next = S_MIN;
            else
                y_next = S'(~quot + 1'b1);
        end
        else
        begin
            if (quot > Q_POS_MAX)
                y_next = S_MAX;
            else
                y_next = S'(quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            stage_reg <= 2'd0;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (ctl.start)
                    begin
                        state_reg <= L_MUL;
                        stage_reg <= 2'd0;
                    end
                end
                L_MUL:
                    state_reg <= L_ADD;
                L_ADD:
                begin
                    if (stage_reg == 2'd2)
                        state_reg <= L_MAG;
                    else
                    begin
                        stage_reg <= stage_reg + 2'd1;
                        state_reg <= L_MUL;
                    end
                end
                L_MAG:
                    state_reg <= L_DIV;
                L_DIV:
                    state_reg <= L_SAT;
                L_SAT:
                    state_reg <= L_DONE;
                L_DONE:
                begin
                    if (ctl.take)
                        state_reg <= L_IDLE;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && ctl.start)
        begin
            acc_reg    <= coef_a;
            coef_b_reg <= coef_b;
            coef_c_reg <= coef_c;
            coef_d_reg <= coef_d;
            t_reg      <= frac;
        end
        if (state_reg == L_MUL)
            prod_reg <= prod_next;
        if (state_reg == L_ADD)
            acc_reg <= acc_next;
        if (state_reg == L_MAG)
        begin
            mag_reg <= abs_acc + ACC_W'(3);
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (state_reg == L_DIV)
            dprod_reg <= dprod_next;
        if (state_reg == L_SAT)
            y_reg <= y_next;
    end

    assign done = (state_reg == L_DONE);
    assign y    = y_reg;

endmodule

/* src/csrc_merge.sv */
// ============================================================================
// csrc_merge: joins the two lane results into one output request
// Owns the output register, so a finished result can wait for the consumer
// while the lanes start on the next one.
// ============================================================================
module csrc_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                left_done,
    input  logic                right_done,
    input  csrc_pkg::sample_t   left_y,
    input  csrc_pkg::sample_t   right_y,
    input  logic                last,
    output logic                take,
    output logic                result_valid,
    input  logic                result_stall,
    output csrc_pkg::out_req_t  result
);

    logic               valid_reg;
    csrc_pkg::out_req_t data_reg;

    assign take = left_done && right_done && (!valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.left_out    <= left_y;
            data_reg.right_out   <= right_y;
            data_reg.last_of_run <= last;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

/* src/cubic_sample_rate_converter_top.sv */
// ============================================================================
// cubic_sample_rate_converter_top: cubic Lagrange sample rate converter
// Stereo or mono resampler with a Q5.F phase accumulator and two lanes.
// ============================================================================
// Operation: an accepted sample launches both lanes once per result; each result
// passes a launch state, three multiply and add pairs, the magnitude, divide
// and saturate steps, and a hand-off into the output register. A sample
// yields 0 to 16 results; the next sample is taken only after its last result
// is handed off, and a full output register that is stalled holds the lanes.
// Reset: asynchronous, active low; histories clear to zero, phase to 1.0,
// step to 1.0 and stereo_mode to mono.
// ============================================================================
module cubic_sample_rate_converter_top #(
    parameter int PHASE_FRAC_BITS = csrc_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Sample channel.
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  csrc_pkg::in_req_t                     sample,
    // Result channel.
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output csrc_pkg::out_req_t                    result,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [csrc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [PHASE_FRAC_BITS+4:0]            cfg_data
);

    localparam int F   = PHASE_FRAC_BITS;
    localparam int PH_W = F + 5;
    localparam logic [PH_W-1:0] PH_ONE   = PH_W'(longint'(1) << F);
    localparam logic [PH_W-1:0] STEP_MIN = PH_W'(longint'(1) << (F - 4));
    localparam logic [PH_W-1:0] STEP_MAX = PH_W'(longint'(1) << (F + 4));
    localparam logic [csrc_pkg::CNT_W-1:0] CNT_LAST =
        csrc_pkg::CNT_W'(csrc_pkg::MAX_OUT - 1);

    // The sequencer: IDLE waits for a sample, START launches both lanes for
    // one phase point, WAIT holds until the merge stage takes their results.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_START = 3'b010,
        S_WAIT  = 3'b100
    } seq_state_t;

    seq_state_t                     state_reg, state_next;
    logic [PH_W-1:0]                step_reg;
    logic                           stereo_reg;
    logic [PH_W-1:0]                phase_reg, phase_next;
    logic [csrc_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    csrc_pkg::hist_t                hist_l_reg, hist_r_reg;

    logic                           accept;
    logic [PH_W-1:0]                step_used;
    logic [PH_W-1:0]                phase_dec;
    logic [PH_W-1:0]                phase_sum;
    logic                           last;
    csrc_pkg::sample_t              right_in;
    csrc_pkg::lane_ctl_t            lane_ctl;
    logic                           take;
    logic                           left_done, right_done;
    csrc_pkg::sample_t              left_y, right_y;

    assign accept = sample_valid && !sample_stall;

    // Samples are only taken while no result of the previous sample is
    // still being computed.
    assign sample_stall = (state_reg != S_IDLE);

    // The step in use is clamped to [1/16, 16] so one sample yields at most
    // sixteen results.
    always_comb
    begin
        if (step_reg < STEP_MIN)
            step_used = STEP_MIN;
        else if (step_reg > STEP_MAX)
            step_used = STEP_MAX;
        else
            step_used = step_reg;
    end

    // Consuming a sample lowers the phase by one; a phase already below one
    // bottoms out at zero.
    assign phase_dec = (phase_reg >= PH_ONE) ? (phase_reg - PH_ONE) : '0;

    // The phase is below one while results are produced, so the sum of phase
    // and clamped step never wraps.
    assign phase_sum = phase_reg + step_used;
    assign last      = (cnt_reg == CNT_LAST) || (phase_sum >= PH_ONE);

    // In mono the right history is fed the left sample.
    assign right_in = stereo_reg ? sample.right_sample : sample.left_sample;

    assign lane_ctl.start = (state_reg == S_START);
    assign lane_ctl.take  = take;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    phase_next = phase_dec;
                    cnt_next   = '0;
                    state_next = (phase_dec < PH_ONE) ? S_START : S_IDLE;
                end
            end
            S_START:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (take)
                begin
                    phase_next = phase_sum;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = last ? S_IDLE : S_START;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_ONE;
            cnt_reg    <= '0;
            step_reg   <= PH_ONE;
            stereo_reg <= 1'b0;
            hist_l_reg <= '0;
            hist_r_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    csrc_pkg::REG_STEP:        step_reg   <= cfg_data;
                    csrc_pkg::REG_STEREO_MODE: stereo_reg <= cfg_data[0];
                    default:                   ;
                endcase
            end
            if (accept)
            begin
                hist_l_reg <= {sample.left_sample, hist_l_reg[3], hist_l_reg[2],
                               hist_l_reg[1]};
                hist_r_reg <= {right_in, hist_r_reg[3], hist_r_reg[2], hist_r_reg[1]};
            end
        end
    end

    // Both lanes run in lockstep on the same phase fraction.
    csrc_lane #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lane_ctl),
        .frac  (phase_reg[F-1:0]),
        .hist  (hist_l_reg),
        .done  (left_done),
        .y     (left_y)
    );

    csrc_lane #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lane_ctl),
        .frac  (phase_reg[F-1:0]),
        .hist  (hist_r_reg),
        .done  (right_done),
        .y     (right_y)
    );

    csrc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .left_done    (left_done),
        .right_done   (right_done),
        .left_y       (left_y),
        .right_y      (right_y),
        .last         (last),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* src/csrc_checker.sv */
// ============================================================================
// csrc_checker: port-level checks for the cubic sample rate converter
// Watches both channels and flags ordering slips between samples and results.
// ============================================================================
module csrc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               sample_stall,
    input  logic               result_valid,
    input  logic               result_stall,
    input  csrc_pkg::out_req_t result
);

    // A stalled result request holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // While a run is still open the block does not take the next sample.
    a_open_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_run |-> sample_stall)
        else $error("sample taken before the run ended");

    // With no sample in work, a drained result is not replaced.
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_stall && result_valid && !result_stall |=> !result_valid)
        else $error("result appeared with no sample in work");

    // A sample request leaves the block busy or idle, never with a stale result.
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && !result_valid |=> !result_valid)
        else $error("result appeared right after a sample was taken");

endmodule

bind cubic_sample_rate_converter_top csrc_checker u_csrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
